// ----- rtl/core/evfs_pkg.sv -----
// evfs_pkg: shared constants for the event queue with statistics
// operation and status codes, field widths and word layout
// no dependencies
`timescale 1ns / 1ps

package evfs_pkg;

    localparam int OP_W       = 2;
    localparam int ID_W       = 5;
    localparam int AUX_W      = 32;
    localparam int STATUS_W   = 2;
    localparam int CNT_W      = 32;
    // id widened far enough to compare against any allowed id count
    localparam int ID_EXT_W   = 9;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 72;

    localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OP_W-1:0] OP_POP   = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_HALTED = 2'd2;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     event_id;
        logic [AUX_W-1:0]    aux_data;
        logic [CNT_W-1:0]    stat_count;
        logic                overflow;
    } result_t;

endpackage

// ----- rtl/core/event_fifo_with_statistics_unit.sv -----
// event_fifo_with_statistics_unit: circular event queue with per-id push counters
// depends on evfs_pkg and evfs_ram
//
// usage:
//   s_* channel carries one operation word: push an event id with an aux word,
//   pop the oldest entry, or query the push count for an id (id 0 gives the
//   total number of pushes, queued plus served). m_* channel returns exactly
//   one result word per operation, in order.
//   each word has an accept step, which issues the reads of the entry ram and
//   the counter ram, and an execute step, which modifies, writes back and loads
//   the output register once the output is free. a new word is taken only once
//   the last has left the execute step, set by that read-then-write sequence on
//   the two rams. a result waiting in the output register does not block the
//   next accept; when the receiver stalls, the second word waits in the execute
//   step and input is held off until the output register drains.
//   reset empties the queue, clears the counters through per-id valid bits and
//   clears the sticky overflow. a push into a full queue sets overflow, and
//   every later word returns a halted status until reset.
`timescale 1ns / 1ps

module event_fifo_with_statistics_unit #(
    parameter int DEPTH     = 32,
    parameter int EVENT_IDS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // op[1:0], event_id[6:2], aux_data[38:7], zero fill[39]
    input  logic [evfs_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // status[1:0], out_event_id[6:2], out_aux_data[38:7], stat_count[70:39], overflow[71]
    output logic [evfs_pkg::OUT_TDATA_W-1:0] m_tdata
);

    import evfs_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int HW = $clog2(EVENT_IDS);
    localparam int EW = ID_W + AUX_W;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic                 state_reg, state_next;
    logic [AW-1:0]        head_reg, head_next;
    logic [AW-1:0]        tail_reg, tail_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]     served_reg, served_next;
    logic                 halted_reg, halted_next;
    logic [EVENT_IDS-1:0] hist_valid_reg, hist_valid_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // operation word captured at accept
    logic [OP_W-1:0]  op_reg;
    logic [ID_W-1:0]  id_reg;
    logic [AUX_W-1:0] aux_reg;

    logic              accept;
    logic              out_free;
    logic              commit;
    logic [ID_W-1:0]   s_id;
    logic [ID_EXT_W-1:0] s_id_ext;
    logic [HW-1:0]     s_hist_addr;
    logic [ID_EXT_W-1:0] id_ext;
    logic [HW-1:0]     hist_addr;
    logic              id_in_range;
    logic              full, empty;

    logic              entry_we;
    logic [EW-1:0]     entry_rdata;
    logic              hist_we;
    logic [CNT_W-1:0]  hist_rdata;
    logic [CNT_W-1:0]  hist_cur;
    logic [CNT_W-1:0]  hist_wdata;

    result_t           res;
    logic              do_push, do_pop, halt_set;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;
    assign commit   = (state_reg == S_EXEC) && out_free;

    assign s_id        = s_tdata[6:2];
    assign s_id_ext    = {{(ID_EXT_W-ID_W){1'b0}}, s_id};
    assign s_hist_addr = s_id_ext[HW-1:0];

    assign id_ext      = {{(ID_EXT_W-ID_W){1'b0}}, id_reg};
    assign hist_addr   = id_ext[HW-1:0];
    assign id_in_range = id_ext < ID_EXT_W'(EVENT_IDS);

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);

    evfs_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (entry_we),
        .waddr (tail_reg),
        .wdata ({id_reg, aux_reg}),
        .re    (accept),
        .raddr (head_reg),
        .rdata (entry_rdata)
    );

    evfs_ram #(
        .WIDTH (CNT_W),
        .DEPTH (EVENT_IDS)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_addr),
        .wdata (hist_wdata),
        .re    (accept),
        .raddr (s_hist_addr),
        .rdata (hist_rdata)
    );

    // a counter never written since reset reads as zero
    assign hist_cur   = hist_valid_reg[hist_addr] ? hist_rdata : '0;
    assign hist_wdata = hist_cur + CNT_W'(1);

    always_comb
    begin
        res      = '0;
        do_push  = 1'b0;
        do_pop   = 1'b0;
        halt_set = 1'b0;
        if (halted_reg)
        begin
            res.status = STATUS_HALTED;
        end
        else
        begin
            case (op_reg)
                OP_PUSH:
                begin
                    if (full)
                    begin
                        halt_set   = 1'b1;
                        res.status = STATUS_HALTED;
                    end
                    else
                    begin
                        do_push = 1'b1;
                    end
                end
                OP_POP:
                begin
                    if (empty)
                    begin
                        res.status = STATUS_EMPTY;
                    end
                    else
                    begin
                        do_pop       = 1'b1;
                        res.event_id = entry_rdata[EW-1:AUX_W];
                        res.aux_data = entry_rdata[AUX_W-1:0];
                    end
                end
                OP_QUERY:
                begin
                    if (id_reg == '0)
                    begin
                        res.stat_count = CNT_W'(count_reg) + served_reg;
                    end
                    else if (id_in_range)
                    begin
                        res.stat_count = hist_cur;
                    end
                end
                default:
                begin
                    res.status = STATUS_OK;
                end
            endcase
        end
        res.overflow = halted_reg || halt_set;
    end

    assign entry_we = commit && do_push;
    assign hist_we  = commit && do_push && id_in_range;

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        served_next     = served_reg;
        halted_next     = halted_reg;
        hist_valid_next = hist_valid_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (commit)
                begin
                    state_next    = S_IDLE;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {res.overflow, res.stat_count, res.aux_data,
                                     res.event_id, res.status};
                    if (halt_set)
                    begin
                        halted_next = 1'b1;
                    end
                    if (do_push)
                    begin
                        tail_next  = (tail_reg == AW'(DEPTH - 1)) ? '0 : tail_reg + AW'(1);
                        count_next = count_reg + CW'(1);
                        if (id_in_range)
                        begin
                            hist_valid_next[hist_addr] = 1'b1;
                        end
                    end
                    if (do_pop)
                    begin
                        head_next   = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
                        count_next  = count_reg - CW'(1);
                        served_next = served_reg + CNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            served_reg     <= '0;
            halted_reg     <= 1'b0;
            hist_valid_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            served_reg     <= served_next;
            halted_reg     <= halted_next;
            hist_valid_reg <= hist_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        if (accept)
        begin
            op_reg  <= s_tdata[1:0];
            id_reg  <= s_tdata[6:2];
            aux_reg <= s_tdata[38:7];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queued count beyond depth");

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == CW'(DEPTH)) |-> head_reg == tail_reg)
        else $error("head and tail disagree with queued count");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt cleared without reset");

    a_no_write_halted: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> !entry_we && !hist_we)
        else $error("memory written while halted");
`endif

endmodule

// ----- rtl/core/evfs_ram.sv -----
// evfs_ram: generic single-write, single-read synchronous ram
// read data is registered and held while no read is issued
// no dependencies
`timescale 1ns / 1ps

module evfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- tb/sv/evfs_tb_pkg.sv -----
// evfs_tb_pkg: expected-result tracker for the event queue testbench
// mirrors queue contents, per-id push counters and the halt flag
// depends on evfs_pkg
`timescale 1ns / 1ps

package evfs_tb_pkg;

    import evfs_pkg::*;

    localparam int QUEUE_DEPTH = 32;
    localparam int ID_COUNT    = 32;

    // op value with no defined action
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    class event_queue_tracker;

        logic [ID_W-1:0]  slot_id  [QUEUE_DEPTH];
        logic [AUX_W-1:0] slot_aux [QUEUE_DEPTH];
        int unsigned      head;
        int unsigned      tail;
        int unsigned      queued;
        logic [CNT_W-1:0] served;
        logic [CNT_W-1:0] pushes_per_id [ID_COUNT];
        bit               halted;
        result_t          pending_results[$];
        int unsigned      failures;

        function new();
            head     = 0;
            tail     = 0;
            queued   = 0;
            served   = '0;
            halted   = 1'b0;
            failures = 0;
            foreach (pushes_per_id[i])
                pushes_per_id[i] = '0;
        endfunction

        // update the mirrored queue for one accepted word and queue its result
        function void predict_result(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                     logic [AUX_W-1:0] aux);
            result_t r;
            r = '0;
            if (halted)
                r.status = STATUS_HALTED;
            else
            begin
                case (op)
                    OP_PUSH:
                    begin
                        if (queued == QUEUE_DEPTH)
                        begin
                            halted   = 1'b1;
                            r.status = STATUS_HALTED;
                        end
                        else
                        begin
                            slot_id[tail]     = id;
                            slot_aux[tail]    = aux;
                            tail              = (tail + 1) % QUEUE_DEPTH;
                            pushes_per_id[id] = pushes_per_id[id] + 1;
                            queued++;
                        end
                    end
                    OP_POP:
                    begin
                        if (queued == 0)
                            r.status = STATUS_EMPTY;
                        else
                        begin
                            r.event_id = slot_id[head];
                            r.aux_data = slot_aux[head];
                            head       = (head + 1) % QUEUE_DEPTH;
                            queued--;
                            served     = served + 1;
                        end
                    end
                    OP_QUERY:
                    begin
                        // id 0 reports all pushes ever accepted
                        if (id == '0)
                            r.stat_count = served + CNT_W'(queued);
                        else
                            r.stat_count = pushes_per_id[id];
                    end
                    default: ;
                endcase
            end
            r.overflow = halted;
            pending_results.push_back(r);
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] word);
            result_t             want;
            logic [STATUS_W-1:0] got_status;
            logic [ID_W-1:0]     got_id;
            logic [AUX_W-1:0]    got_aux;
            logic [CNT_W-1:0]    got_count;
            logic                got_overflow;
            if (pending_results.size() == 0)
            begin
                $error("result word %h arrived with nothing outstanding", word);
                failures++;
                return;
            end
            want         = pending_results.pop_front();
            got_status   = word[1:0];
            got_id       = word[6:2];
            got_aux      = word[38:7];
            got_count    = word[70:39];
            got_overflow = word[71];
            if (got_status !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, got_status);
                failures++;
            end
            if (got_id !== want.event_id)
            begin
                $error("out_event_id: expected %0d, actual %0d", want.event_id, got_id);
                failures++;
            end
            if (got_aux !== want.aux_data)
            begin
                $error("out_aux_data: expected %h, actual %h", want.aux_data, got_aux);
                failures++;
            end
            if (got_count !== want.stat_count)
            begin
                $error("stat_count: expected %0d, actual %0d", want.stat_count, got_count);
                failures++;
            end
            if (got_overflow !== want.overflow)
            begin
                $error("overflow: expected %0d, actual %0d", want.overflow, got_overflow);
                failures++;
            end
        endfunction

    endclass

endpackage

// ----- tb/sv/event_fifo_with_statistics_unit_test.sv -----
// event_fifo_with_statistics_unit_test: drives push, pop, query and unused-op words with random
// gaps and stalls and checks every result word against event_queue_tracker
// depends on evfs_pkg, evfs_tb_pkg and event_fifo_with_statistics_unit
`timescale 1ns / 1ps

module event_fifo_with_statistics_unit_test;

    import evfs_pkg::*;
    import evfs_tb_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    event_queue_tracker tracker;
    int                 src_idle_pct   = 0;
    int                 sink_stall_pct = 0;
    int                 hold_req       = 0;
    int                 hold_left      = 0;
    int unsigned        cycle_count    = 0;

    event_fifo_with_statistics_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("event_fifo_with_statistics_unit regression: fail");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off when one is requested
    always @(negedge clk)
    begin
        if (hold_req != 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= (sink_stall_pct == 0) || ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_result(m_tdata);
    end

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic send_word(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                             input logic [AUX_W-1:0] aux);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, aux, id, op};
        do
            @(posedge clk);
        while (!s_tready);
        tracker.predict_result(op, id, aux);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (tracker.pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_random(input int n, input int src_pct, input int sink_pct);
        int              push_pct;
        int              r;
        logic [OP_W-1:0] op;
        logic [ID_W-1:0] id;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        push_pct       = 70;
        for (int i = 0; i < n; i++)
        begin
            // swing between filling and draining so both ends of the queue get hit
            if (i % 48 == 47)
                push_pct = 100 - push_pct;
            r = $urandom_range(99);
            if (r < push_pct)
                op = OP_PUSH;
            else
            begin
                r = $urandom_range(9);
                op = (r < 6) ? OP_POP : (r < 9) ? OP_QUERY : OP_UNUSED;
            end
            // a push into a full queue halts the block for good, keep that for the end
            if (op == OP_PUSH && tracker.queued == QUEUE_DEPTH)
                op = OP_POP;
            id = ($urandom_range(3) == 0) ? '0 : ID_W'($urandom);
            send_word(op, id, $urandom());
        end
    endtask

    initial
    begin
        tracker = new();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty queue, zero counters, unused op
        send_word(OP_POP,    5'd0,  32'h0);
        send_word(OP_QUERY,  5'd0,  32'hffff_ffff);
        send_word(OP_QUERY,  5'd31, 32'h0);
        send_word(OP_UNUSED, 5'd31, 32'hffff_ffff);
        // extremes of id and aux word
        send_word(OP_PUSH,   5'd0,  32'h0);
        send_word(OP_PUSH,   5'd31, 32'hffff_ffff);
        send_word(OP_PUSH,   5'd21, 32'h5555_aaaa);
        send_word(OP_PUSH,   5'd31, 32'haaaa_5555);
        send_word(OP_QUERY,  5'd0,  32'h0);
        send_word(OP_QUERY,  5'd31, 32'h0);
        send_word(OP_QUERY,  5'd21, 32'h0);
        send_word(OP_UNUSED, 5'd10, 32'h1234_5678);
        send_word(OP_POP,    5'd31, 32'hffff_ffff);
        send_word(OP_POP,    5'd0,  32'h0);
        send_word(OP_POP,    5'd0,  32'h0);
        send_word(OP_POP,    5'd0,  32'h0);
        send_word(OP_POP,    5'd0,  32'h0);
        // total pushes now all come from the served side
        send_word(OP_QUERY,  5'd0,  32'h0);
        wait_drained();

        run_random(210, 0, 0);
        wait_drained();
        run_random(200, 84, 0);
        wait_drained();
        run_random(200, 0, 84);
        wait_drained();

        // long receiver hold-off while words keep coming, input must back up
        hold_req = 150;
        run_random(40, 0, 0);
        wait_drained();

        run_random(200, 37, 37);
        wait_drained();

        // fill to the brim, overflow, then everything reports halted
        src_idle_pct   = 20;
        sink_stall_pct = 30;
        while (tracker.queued < QUEUE_DEPTH)
            send_word(OP_PUSH, ID_W'($urandom), $urandom());
        send_word(OP_QUERY,  5'd0,  32'h0);
        send_word(OP_PUSH,   5'd7,  32'hdead_beef);
        send_word(OP_POP,    5'd0,  32'h0);
        send_word(OP_QUERY,  5'd0,  32'h0);
        send_word(OP_QUERY,  5'd7,  32'h0);
        send_word(OP_UNUSED, 5'd31, 32'hffff_ffff);
        send_word(OP_PUSH,   5'd3,  32'h0000_0001);
        wait_drained();

        repeat (10) @(posedge clk);
        if (tracker.failures == 0 && tracker.pending_results.size() == 0)
            $display("event_fifo_with_statistics_unit regression: pass");
        else
            $display("event_fifo_with_statistics_unit regression: fail");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/evfs_pkg.sv
rtl/core/evfs_ram.sv
rtl/core/event_fifo_with_statistics_unit.sv
tb/sv/evfs_tb_pkg.sv
tb/sv/event_fifo_with_statistics_unit_test.sv
